// ===== src/awad_pkg.sv =====
package awad_pkg;

  localparam int CHAN_W  = 8;
  localparam int COORD_W = 8;
  localparam int CFG_W   = 9;
  localparam int PIXEL_W = 4 * CHAN_W;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // pixel store geometry, tied to the 8-bit coordinates and 9-bit sides
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // accumulator widths: area <= 511*511, sums scale by 255 per channel factor
  localparam int AREA_W = 18;
  localparam int ASUM_W = 26;
  localparam int CSUM_W = 34;
  localparam int WGT_W  = 16;
  localparam int AW_W   = 24;
  localparam int CW_W   = 32;
  localparam int POS_W  = 18;

  // divider lanes: numerator 2*num+den, quotient below 512
  localparam int DIV_W  = 36;
  localparam int QUO_W  = 9;
  localparam int DCNT_W = 4;
  localparam int DIV_STEPS = QUO_W;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_WGT,
    ST_PIX,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== src/alpha_weighted_area_downsample.sv =====
// Mipmap level generator with alpha-weighted area averaging.
// Input channel (in_valid_i / in_stall_o): cmd_i = load writes one RGBA source
// pixel at (column_i, row_index_i) and gives no result beat;
// cmd_i = compute asks for one pixel of the half-size image and gives one
// result beat on the output channel (out_valid_o / out_stall_i side stall).
// Source size is set over the APB port: width at 0x0, height at 0x4.
// A compute walks the covering source window (up to 3x3 pixels) through the
// pixel memory, one read a cycle into a four-stage multiply/accumulate pipe,
// then runs four restoring dividers in parallel, one quotient bit a cycle.
// A compute runs the window setup, the pixel reads and pipe drain, the divide,
// and then loads the output register.
// An out-of-range compute skips the window and answers with status 1.
// One item is worked on at a time; a load is taken every cycle while idle.
// The output register holds a result while the receiver stalls; the next item
// is still accepted, and a compute waits at its end for the register to free.
// Reset sets both sides to 1 and empties the output register; pixel memory
// is not cleared and must be loaded before a compute reads it.
module alpha_weighted_area_downsample
  import awad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [COORD_W-1:0] column_i,
  input  logic [COORD_W-1:0] row_index_i,
  input  logic [CHAN_W-1:0]  red_in_i,
  input  logic [CHAN_W-1:0]  green_in_i,
  input  logic [CHAN_W-1:0]  blue_in_i,
  input  logic [CHAN_W-1:0]  alpha_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAN_W-1:0]  red_out_o,
  output logic [CHAN_W-1:0]  green_out_o,
  output logic [CHAN_W-1:0]  blue_out_o,
  output logic [CHAN_W-1:0]  alpha_out_o,
  output logic               status_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [CFG_W-1:0] width_q, height_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? APB_DW'(height_q) : APB_DW'(width_q);

  logic [CFG_W-1:0]   sw, sh;
  logic [COORD_W-1:0] dw, dh;

  always_comb begin
    if (width_q == '0) sw = CFG_W'(1);
    else if (32'(width_q) > MAX_WIDTH) sw = CFG_W'(MAX_WIDTH);
    else sw = width_q;
    if (height_q == '0) sh = CFG_W'(1);
    else if (32'(height_q) > MAX_HEIGHT) sh = CFG_W'(MAX_HEIGHT);
    else sh = height_q;
    dw = (sw[CFG_W-1:1] == '0) ? COORD_W'(1) : sw[CFG_W-1:1];
    dh = (sh[CFG_W-1:1] == '0) ? COORD_W'(1) : sh[CFG_W-1:1];
  end

  // control
  state_e state_q, state_d;
  logic   in_acc, out_free;
  logic   v1_q, v2_q, v3_q;
  logic   out_valid_q;
  logic   iss_done_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic   err_q;
  logic [COORD_W-1:0] col_q, row_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  logic oob;
  assign oob = (column_i >= dw) || (row_index_i >= dh);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd_i == CMD_COMPUTE) state_d = oob ? ST_DONE : ST_WIN;
      end
      ST_WIN:  state_d = ST_WGT;
      ST_WGT:  state_d = ST_PIX;
      ST_PIX: begin
        if (iss_done_q && !v1_q && !v2_q && !v3_q) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // window setup
  logic [POS_W-1:0]  left_q, right_q, top_q, bottom_q, bx_q, by_q;
  logic [CFG_W:0]    x1_q, y1_q;
  logic [CFG_W-1:0]  x0, y0;
  logic [CFG_W:0]    x1_c, y1_c;
  logic [CHAN_W-1:0] wx_d [3];
  logic [CHAN_W-1:0] wy_d [3];
  logic [CHAN_W-1:0] wx_q [3];
  logic [CHAN_W-1:0] wy_q [3];

  assign x0 = {col_q, 1'b0};
  assign y0 = {row_q, 1'b0};

  always_comb begin
    x1_c = (CFG_W+1)'(x0) + (CFG_W+1)'(2) + (CFG_W+1)'(sw[0]);
    if (x1_c > (CFG_W+1)'(sw)) x1_c = (CFG_W+1)'(sw);
    y1_c = (CFG_W+1)'(y0) + (CFG_W+1)'(2) + (CFG_W+1)'(sh[0]);
    if (y1_c > (CFG_W+1)'(sh)) y1_c = (CFG_W+1)'(sh);
  end

  // per-lane overlap of each source column/row with the output interval
  always_comb begin
    logic [POS_W-1:0] lo, hi, a, b;
    for (int j = 0; j < 3; j++) begin
      lo = bx_q + POS_W'(dw) * POS_W'(j);
      hi = lo + POS_W'(dw);
      a  = (lo > left_q) ? lo : left_q;
      b  = (hi < right_q) ? hi : right_q;
      wx_d[j] = (b > a && ((CFG_W+1)'(x0) + (CFG_W+1)'(j)) < x1_q) ? CHAN_W'(b - a) : '0;
      lo = by_q + POS_W'(dh) * POS_W'(j);
      hi = lo + POS_W'(dh);
      a  = (lo > top_q) ? lo : top_q;
      b  = (hi < bottom_q) ? hi : bottom_q;
      wy_d[j] = (b > a && ((CFG_W+1)'(y0) + (CFG_W+1)'(j)) < y1_q) ? CHAN_W'(b - a) : '0;
    end
  end

  // pixel memory
  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      waddr, raddr;
  logic [1:0]         cx_q, cy_q;
  logic               inw;

  assign mem_we = in_acc && cmd_i == CMD_LOAD && 32'(column_i) < MAX_WIDTH
                  && 32'(row_index_i) < MAX_HEIGHT;
  assign waddr  = AW'(32'(row_index_i) * MAX_WIDTH + 32'(column_i));
  assign inw    = (wx_q[cx_q] != '0) && (wy_q[cy_q] != '0);
  assign mem_re = (state_q == ST_PIX) && !iss_done_q && inw;
  assign raddr  = AW'((32'(y0) + 32'(cy_q)) * MAX_WIDTH + 32'(x0) + 32'(cx_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= {alpha_in_i, blue_in_i, green_in_i, red_in_i};
    if (mem_re) rdata_q <= mem[raddr];
  end

  // multiply/accumulate pipe
  logic [WGT_W-1:0]   wgt1_q, wgt2_q;
  logic               inw1_q;
  logic [PIXEL_W-1:0] px;
  logic [AW_W-1:0]    aw2_q;
  logic [AW_W-1:0]    uw2_q [3];
  logic [CHAN_W-1:0]  ch2_q [3];
  logic [CW_W-1:0]    cw3_q [3];
  logic [AREA_W-1:0]  area_q;
  logic [ASUM_W-1:0]  asum_q;
  logic [ASUM_W-1:0]  usum_q [3];
  logic [CSUM_W-1:0]  csum_q [3];

  assign px = inw1_q ? rdata_q : '0;

  // dividers
  logic [DIV_W-1:0] rem_q [4];
  logic [DIV_W-1:0] dsh_q [4];
  logic [QUO_W-1:0] quo_q [4];
  logic [CSUM_W-1:0] num_c [4];
  logic [ASUM_W-1:0] den_c [4];
  logic [AREA_W-1:0] area_nz;

  always_comb begin
    area_nz = (area_q == '0) ? AREA_W'(1) : area_q;
    for (int k = 0; k < 3; k++) begin
      num_c[k] = (asum_q != '0) ? csum_q[k] : CSUM_W'(usum_q[k]);
      den_c[k] = (asum_q != '0) ? asum_q : ASUM_W'(area_nz);
    end
    num_c[3] = CSUM_W'(asum_q);
    den_c[3] = ASUM_W'(area_nz);
  end

  function automatic logic [CHAN_W-1:0] sat8(input logic [QUO_W-1:0] q);
    return q[QUO_W-1] ? '1 : q[CHAN_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      col_q <= column_i;
      row_q <= row_index_i;
    end
    if (state_q == ST_WIN) begin
      left_q   <= POS_W'(col_q * sw);
      right_q  <= POS_W'((POS_W'(col_q) + POS_W'(1)) * POS_W'(sw));
      top_q    <= POS_W'(row_q * sh);
      bottom_q <= POS_W'((POS_W'(row_q) + POS_W'(1)) * POS_W'(sh));
      bx_q     <= POS_W'(x0 * dw);
      by_q     <= POS_W'(y0 * dh);
      x1_q     <= x1_c;
      y1_q     <= y1_c;
    end
    if (state_q == ST_WGT) begin
      wx_q <= wx_d;
      wy_q <= wy_d;
      area_q <= '0;
      asum_q <= '0;
      for (int k = 0; k < 3; k++) begin
        usum_q[k] <= '0;
        csum_q[k] <= '0;
      end
    end
    if (state_q == ST_PIX && !iss_done_q) begin
      wgt1_q <= inw ? WGT_W'(wx_q[cx_q] * wy_q[cy_q]) : '0;
      inw1_q <= inw;
    end
    if (v1_q) begin
      aw2_q  <= AW_W'(px[PIXEL_W-1 -: CHAN_W] * wgt1_q);
      wgt2_q <= wgt1_q;
      for (int k = 0; k < 3; k++) begin
        uw2_q[k] <= AW_W'(px[CHAN_W*k +: CHAN_W] * wgt1_q);
        ch2_q[k] <= px[CHAN_W*k +: CHAN_W];
      end
    end
    if (v2_q) begin
      area_q <= area_q + AREA_W'(wgt2_q);
      asum_q <= asum_q + ASUM_W'(aw2_q);
      for (int k = 0; k < 3; k++) begin
        cw3_q[k]  <= CW_W'(ch2_q[k] * aw2_q);
        usum_q[k] <= usum_q[k] + ASUM_W'(uw2_q[k]);
      end
    end
    if (v3_q) begin
      for (int k = 0; k < 3; k++) csum_q[k] <= csum_q[k] + CSUM_W'(cw3_q[k]);
    end
    if (state_q == ST_PIX && state_d == ST_DIV) begin
      for (int k = 0; k < 4; k++) begin
        rem_q[k] <= DIV_W'({num_c[k], 1'b0}) + DIV_W'(den_c[k]);
        dsh_q[k] <= DIV_W'({den_c[k], 1'b0}) << (QUO_W - 1);
        quo_q[k] <= '0;
      end
    end else if (state_q == ST_DIV) begin
      for (int k = 0; k < 4; k++) begin
        if (rem_q[k] >= dsh_q[k]) begin
          rem_q[k] <= rem_q[k] - dsh_q[k];
          quo_q[k] <= {quo_q[k][QUO_W-2:0], 1'b1};
        end else begin
          quo_q[k] <= {quo_q[k][QUO_W-2:0], 1'b0};
        end
        dsh_q[k] <= dsh_q[k] >> 1;
      end
    end
    if (state_q == ST_DONE && out_free) begin
      red_out_o   <= err_q ? '0 : sat8(quo_q[0]);
      green_out_o <= err_q ? '0 : sat8(quo_q[1]);
      blue_out_o  <= err_q ? '0 : sat8(quo_q[2]);
      alpha_out_o <= err_q ? '0 : sat8(quo_q[3]);
      status_o    <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= CFG_W'(1);
      height_q    <= CFG_W'(1);
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      iss_done_q  <= 1'b0;
      cx_q        <= '0;
      cy_q        <= '0;
      div_cnt_q   <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_HEIGHT) height_q <= pwdata[CFG_W-1:0];
        else width_q <= pwdata[CFG_W-1:0];
      end
      if (in_acc && cmd_i == CMD_COMPUTE) err_q <= oob;
      v1_q <= (state_q == ST_PIX) && !iss_done_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (state_q == ST_WGT) begin
        cx_q       <= '0;
        cy_q       <= '0;
        iss_done_q <= 1'b0;
      end else if (state_q == ST_PIX && !iss_done_q) begin
        // walk the 3x3 window row by row
        if (cx_q == 2'd2) begin
          cx_q <= '0;
          if (cy_q == 2'd2) iss_done_q <= 1'b1;
          else cy_q <= cy_q + 2'd1;
        end else begin
          cx_q <= cx_q + 2'd1;
        end
      end
      if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + DCNT_W'(1);
      else div_cnt_q <= '0;
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result beat without a finished compute");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (red_out_o == '0 && green_out_o == '0
      && blue_out_o == '0 && alpha_out_o == '0))
    else $error("error beat carries channel data");

  a_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (!v1_q && !v2_q && !v3_q && iss_done_q))
    else $error("divide started before accumulation finished");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_cnt_q < DCNT_W'(DIV_STEPS)))
    else $error("divider ran past its quotient width");

endmodule
